// File: rtl/core/mdscb_pkg.sv
// shared constants, types and weight conversion for the masked crossfade blend
package mdscb_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned PixW      = 3 * ChanW;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned PctW      = 8;
  localparam int unsigned WeightW   = 9;
  localparam int unsigned TotalW    = ChanW + 1;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [WeightW-1:0] FullWeight = 9'd256;
  localparam logic [ChanW-1:0]   ChanMax    = 8'd255;
  localparam logic [16:0]        PctRound   = 17'd50;
  // ceil(2^24 / 100), exact floor division by 100 for 17-bit dividends
  localparam logic [17:0]        PctRecip   = 18'd167773;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_PERCENT  = 2'd0,
    CFG_SECOND_PERCENT = 2'd1
  } mdscb_cfg_e;

  // per-stage load enables handed to the channel datapath
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } mdscb_adv_t;

  // (p*256+50)/100, capped at 256
  function automatic logic [WeightW-1:0] pct_to_weight(input logic [PctW-1:0] pct);
    logic [16:0] num;
    logic [34:0] prod;
    logic [10:0] quo;
    num  = {1'b0, pct, 8'd0} + PctRound;
    prod = 35'(num) * 35'(PctRecip);
    quo  = prod[34:24];
    if (quo > 11'(FullWeight)) begin
      return FullWeight;
    end
    return quo[WeightW-1:0];
  endfunction

endpackage

// File: rtl/core/mdscb_channel.sv
// one color channel of the blend datapath, stages two to four
module mdscb_channel (
  input  logic                     clk_i,
  input  mdscb_pkg::mdscb_adv_t    adv_i,
  input  logic [7:0]               first_chan_i,
  input  logic [7:0]               second_chan_i,
  input  logic [7:0]               back_chan_i,
  input  logic [7:0]               first_eff_i,
  input  logic [7:0]               second_eff_i,
  output logic [7:0]               result_o
);
  import mdscb_pkg::*;

  logic [ChanW-1:0]  src_d, src_q;
  logic [ChanW-1:0]  back2_q;
  logic [TotalW-1:0] total_d, total_q;
  logic [16:0]       src_prod_d, src_prod_q;
  logic signed [18:0] back_prod_d, back_prod_q;
  logic [ChanW-1:0]  result_d, result_q;

  logic [16:0]        src_sum;
  logic signed [9:0]  back_fac;
  logic signed [18:0] mix;

  // stage two: weighted source sum and total weight
  always_comb begin
    src_sum = 17'(16'(first_chan_i) * 16'(first_eff_i))
            + 17'(16'(second_chan_i) * 16'(second_eff_i));
    if (src_sum[16:8] > 9'(ChanMax)) begin
      src_d = ChanMax;
    end else begin
      src_d = src_sum[15:8];
    end
    total_d = 9'(first_eff_i) + 9'(second_eff_i);
  end

  // stage three: source and destination products
  always_comb begin
    back_fac    = 10'sd256 - $signed({1'b0, total_q});
    src_prod_d  = 17'(src_q) * 17'(total_q);
    back_prod_d = 19'($signed({1'b0, back2_q})) * 19'(back_fac);
  end

  // stage four: mix, shift and clamp
  always_comb begin
    mix = $signed({2'b00, src_prod_q}) + back_prod_q;
    if (mix[18]) begin
      result_d = '0;
    end else if (mix[17:8] > 10'(ChanMax)) begin
      result_d = ChanMax;
    end else begin
      result_d = mix[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      src_q   <= src_d;
      total_q <= total_d;
      back2_q <= back_chan_i;
    end
    if (adv_i.s3) begin
      src_prod_q  <= src_prod_d;
      back_prod_q <= back_prod_d;
    end
    if (adv_i.s4) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// File: rtl/core/masked_dual_source_crossfade_blend.sv
// top level of the masked two-source crossfade blend, rgb888
// Blends one RGB888 pixel per item from two masked sources and the destination pixel.
// The datapath is four register stages (mask weighting, source sum, mix products,
// mix sum and clamp, which is also the output register). A result moves through the
// stages in order and is held on the output while the output is stalled. A new item
// is taken every cycle; the input stalls only when all four
// stages hold items and the output is stalled. Percent registers are written through
// the plain write port and are converted to /256 weights at the write; index 0 is the
// first source, index 1 the second, other indexes are ignored.
module masked_dual_source_crossfade_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mdscb_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mdscb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [23:0]                   first_pixel_i,
  input  logic [23:0]                   second_pixel_i,
  input  logic [7:0]                    first_mask_i,
  input  logic [7:0]                    second_mask_i,
  input  logic [23:0]                   background_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [23:0]                   blended_pixel_o
);
  import mdscb_pkg::*;

  logic [WeightW-1:0] first_w_d, first_w_q;
  logic [WeightW-1:0] second_w_d, second_w_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  mdscb_adv_t adv;

  logic [PixW-1:0]  first_pix_q, second_pix_q, back_pix_q;
  logic [ChanW-1:0] first_eff_q, second_eff_q;
  logic [16:0]      first_eprod, second_eprod;

  // config write decode
  always_comb begin
    first_w_d  = first_w_q;
    second_w_d = second_w_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_PERCENT:  first_w_d  = pct_to_weight(cfg_data_i);
        CFG_SECOND_PERCENT: second_w_d = pct_to_weight(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_w_q  <= pct_to_weight('0);
      second_w_q <= pct_to_weight('0);
    end else begin
      first_w_q  <= first_w_d;
      second_w_q <= second_w_d;
    end
  end

  // pipeline flow control
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage one: effective weights from masks
  assign first_eprod  = 17'(first_w_q) * 17'(first_mask_i);
  assign second_eprod = 17'(second_w_q) * 17'(second_mask_i);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      first_pix_q  <= first_pixel_i;
      second_pix_q <= second_pixel_i;
      back_pix_q   <= background_pixel_i;
      first_eff_q  <= first_eprod[15:8];
      second_eff_q <= second_eprod[15:8];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    mdscb_channel u_chan (
      .clk_i         (clk_i),
      .adv_i         (adv),
      .first_chan_i  (first_pix_q[c*ChanW +: ChanW]),
      .second_chan_i (second_pix_q[c*ChanW +: ChanW]),
      .back_chan_i   (back_pix_q[c*ChanW +: ChanW]),
      .first_eff_i   (first_eff_q),
      .second_eff_i  (second_eff_q),
      .result_o      (blended_pixel_o[c*ChanW +: ChanW])
    );
  end

  assign out_valid_o = v4_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a free pipeline stage");

  a_weight_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_w_q <= FullWeight) && (second_w_q <= FullWeight))
    else $error("weight above full scale");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v3_q) |=> !out_valid_o)
    else $error("result repeated after delivery");

endmodule

// File: verif/tb_top.sv
// testbench for the masked crossfade blend: directed table and random pixels vs a predictor
`timescale 1ns / 1ps

module tb_top;
  import mdscb_pkg::*;

  localparam logic [CfgIdxW-1:0] SpareIdxLo = 2'd2;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 2'd3;
  localparam int NumRows = 24;
  localparam int NumSegments = 8;
  localparam int SegmentItems = 168;

  typedef struct packed {
    logic [PctW-1:0]  pct_a;
    logic [PctW-1:0]  pct_b;
    logic [PixW-1:0]  src_a;
    logic [PixW-1:0]  src_b;
    logic [MaskW-1:0] mask_a;
    logic [MaskW-1:0] mask_b;
    logic [PixW-1:0]  dest;
    logic             fixed_on;
    logic [PixW-1:0]  fixed_px;
  } blend_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [23:0]         first_pixel_i;
  logic [23:0]         second_pixel_i;
  logic [7:0]          first_mask_i;
  logic [7:0]          second_mask_i;
  logic [23:0]         background_pixel_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [23:0]         blended_pixel_o;

  logic                fixed_on_q;
  logic [PixW-1:0]     fixed_px_q;

  logic [PixW-1:0]     pending_pixels[$];
  logic [PctW-1:0]     model_pct_a;
  logic [PctW-1:0]     model_pct_b;
  logic [PctW-1:0]     cur_pct_a;
  logic [PctW-1:0]     cur_pct_b;
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         fail_cnt;
  int unsigned         items_taken;
  int unsigned         pixels_checked;
  int unsigned         settings_used;
  int unsigned         stalls_seen;

  blend_row_t blend_rows [NumRows] = '{
    '{8'd0,   8'd0,   24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 24'h123456, 1'b1, 24'h123456},
    '{8'd0,   8'd0,   24'h000000, 24'hFFFFFF, 8'h00, 8'hFF, 24'hA5A5A5, 1'b1, 24'hA5A5A5},
    '{8'd100, 8'd100, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 8'h00, 24'h5A5A5A, 1'b1, 24'h5A5A5A},
    '{8'd100, 8'd100, 24'hFFFFFF, 24'h000000, 8'hFF, 8'h00, 24'h000000, 1'b0, 24'h0},
    '{8'd100, 8'd100, 24'h000000, 24'hFFFFFF, 8'h00, 8'hFF, 24'hFFFFFF, 1'b0, 24'h0},
    '{8'd100, 8'd100, 24'hFF0000, 24'h00FF00, 8'hFF, 8'hFF, 24'h0000FF, 1'b0, 24'h0},
    '{8'd100, 8'd100, 24'h808080, 24'h7F7F7F, 8'h80, 8'h7F, 24'h010203, 1'b0, 24'h0},
    '{8'd100, 8'd100, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 24'h000000, 1'b0, 24'h0},
    '{8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 24'h000000, 1'b1, 24'hFFFFFF},
    '{8'd255, 8'd255, 24'h000000, 24'h000000, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1, 24'h000000},
    '{8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 8'h00, 8'h00, 24'hABCDEF, 1'b1, 24'hABCDEF},
    '{8'd255, 8'd255, 24'h123456, 24'hFEDCBA, 8'hFF, 8'h01, 24'h808080, 1'b0, 24'h0},
    '{8'd255, 8'd255, 24'h00FF00, 24'hFF00FF, 8'h80, 8'h80, 24'h00FF00, 1'b0, 24'h0},
    '{8'd255, 8'd0,   24'hFFFFFF, 24'h000000, 8'hFF, 8'hFF, 24'h000000, 1'b0, 24'h0},
    '{8'd255, 8'd0,   24'h0F0F0F, 24'hF0F0F0, 8'h01, 8'hFF, 24'hFFFFFF, 1'b0, 24'h0},
    '{8'd0,   8'd255, 24'h000000, 24'hFFFFFF, 8'hFF, 8'hFF, 24'h000000, 1'b0, 24'h0},
    '{8'd1,   8'd254, 24'hFFFFFF, 24'h000000, 8'hFF, 8'hFF, 24'h7F7F7F, 1'b0, 24'h0},
    '{8'd1,   8'd254, 24'h000000, 24'hFFFFFF, 8'hFE, 8'h02, 24'h7F7F7F, 1'b0, 24'h0},
    '{8'd50,  8'd50,  24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 24'h000000, 1'b0, 24'h0},
    '{8'd50,  8'd50,  24'h555555, 24'hAAAAAA, 8'hFF, 8'hFF, 24'h333333, 1'b0, 24'h0},
    '{8'd101, 8'd99,  24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b0, 24'h0},
    '{8'd101, 8'd99,  24'h010101, 24'hFEFEFE, 8'hFF, 8'h80, 24'h7F7F7F, 1'b0, 24'h0},
    '{8'd200, 8'd60,  24'h000000, 24'h101010, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b0, 24'h0},
    '{8'd200, 8'd60,  24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 24'h000000, 1'b0, 24'h0}
  };

  masked_dual_source_crossfade_blend u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .first_pixel_i      (first_pixel_i),
    .second_pixel_i     (second_pixel_i),
    .first_mask_i       (first_mask_i),
    .second_mask_i      (second_mask_i),
    .background_pixel_i (background_pixel_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .blended_pixel_o    (blended_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // percent to /256 weight, rounded and capped
  function automatic int unsigned pct_weight(input logic [PctW-1:0] pct);
    int unsigned w;
    w = (int'(pct) * 256 + 50) / 100;
    return (w > 256) ? 256 : w;
  endfunction

  function automatic logic [PixW-1:0] crossfade_pixel(
    input logic [PixW-1:0]  src_a,
    input logic [PixW-1:0]  src_b,
    input logic [MaskW-1:0] mask_a,
    input logic [MaskW-1:0] mask_b,
    input logic [PixW-1:0]  dest,
    input logic [PctW-1:0]  pct_a,
    input logic [PctW-1:0]  pct_b
  );
    int eff_a;
    int eff_b;
    int total;
    int src;
    int mix;
    logic [PixW-1:0] px;
    eff_a = (pct_weight(pct_a) * int'(mask_a)) >> 8;
    eff_b = (pct_weight(pct_b) * int'(mask_b)) >> 8;
    total = eff_a + eff_b;
    px = '0;
    for (int ch = 0; ch < 3; ch++) begin
      src = (int'(src_a[ch*8 +: 8]) * eff_a + int'(src_b[ch*8 +: 8]) * eff_b) >> 8;
      if (src > 255) src = 255;
      mix = src * total + int'(dest[ch*8 +: 8]) * (256 - total);
      if (mix < 0) begin
        mix = 0;
      end else begin
        mix = mix / 256;
        if (mix > 255) mix = 255;
      end
      px[ch*8 +: 8] = mix[7:0];
    end
    return px;
  endfunction

  // result check, then new expectation and register tracking
  always @(posedge clk_i) begin
    logic [PixW-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_stall_i) stalls_seen++;
      if (out_valid_o && !out_stall_i) begin
        pixels_checked++;
        if (pending_pixels.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected result %06h", $realtime, blended_pixel_o);
        end else begin
          want = pending_pixels.pop_front();
          if (blended_pixel_o !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: blended_pixel expected %06h got %06h",
                       $realtime, want, blended_pixel_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        items_taken++;
        if (fixed_on_q) begin
          pending_pixels.push_back(fixed_px_q);
        end else begin
          pending_pixels.push_back(crossfade_pixel(first_pixel_i, second_pixel_i,
                                                   first_mask_i, second_mask_i,
                                                   background_pixel_i,
                                                   model_pct_a, model_pct_b));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_PERCENT:  model_pct_a = cfg_data_i;
          CFG_SECOND_PERCENT: model_pct_b = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic send_pixel(
    input logic [PixW-1:0]  src_a,
    input logic [PixW-1:0]  src_b,
    input logic [MaskW-1:0] mask_a,
    input logic [MaskW-1:0] mask_b,
    input logic [PixW-1:0]  dest,
    input logic             fixed_on,
    input logic [PixW-1:0]  fixed_px
  );
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i         <= 1'b1;
    first_pixel_i      <= src_a;
    second_pixel_i     <= src_b;
    first_mask_i       <= mask_a;
    second_mask_i      <= mask_b;
    background_pixel_i <= dest;
    fixed_on_q         <= fixed_on;
    fixed_px_q         <= fixed_px;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // spare indexes get junk after the real writes, which must not stick
  task automatic set_percents(input logic [PctW-1:0] pct_a, input logic [PctW-1:0] pct_b);
    drain_pipe();
    write_reg(CFG_FIRST_PERCENT, pct_a);
    write_reg(CFG_SECOND_PERCENT, pct_b);
    write_reg(SpareIdxLo, CfgDataW'($urandom));
    write_reg(SpareIdxHi, CfgDataW'($urandom));
    cfg_we_i  <= 1'b0;
    cur_pct_a = pct_a;
    cur_pct_b = pct_b;
    settings_used++;
  endtask

  function automatic logic [MaskW-1:0] rand_mask();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return MaskW'($urandom);
  endfunction

  function automatic logic [PixW-1:0] rand_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PixW'($urandom);
  endfunction

  initial begin
    logic [PctW-1:0] pa;
    logic [PctW-1:0] pb;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_FIRST_PERCENT;
    cfg_data_i         <= '0;
    in_valid_i         <= 1'b0;
    first_pixel_i      <= '0;
    second_pixel_i     <= '0;
    first_mask_i       <= '0;
    second_mask_i      <= '0;
    background_pixel_i <= '0;
    fixed_on_q         <= 1'b0;
    fixed_px_q         <= '0;
    model_pct_a    = '0;
    model_pct_b    = '0;
    cur_pct_a      = '0;
    cur_pct_b      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_cnt       = 0;
    items_taken    = 0;
    pixels_checked = 0;
    settings_used  = 1;
    stalls_seen    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (blend_rows[i]) begin
      if (blend_rows[i].pct_a != cur_pct_a || blend_rows[i].pct_b != cur_pct_b)
        set_percents(blend_rows[i].pct_a, blend_rows[i].pct_b);
      send_pixel(blend_rows[i].src_a, blend_rows[i].src_b, blend_rows[i].mask_a,
                 blend_rows[i].mask_b, blend_rows[i].dest, blend_rows[i].fixed_on,
                 blend_rows[i].fixed_px);
    end

    for (int seg = 0; seg < NumSegments; seg++) begin
      case (seg)
        0: begin pa = 8'd100; pb = 8'd100; end
        1: begin pa = 8'd255; pb = 8'd0;   end
        2: begin pa = 8'd0;   pb = 8'd255; end
        3: begin pa = 8'd255; pb = 8'd255; end
        default: begin
          pa = PctW'($urandom_range(0, 130));
          pb = PctW'($urandom_range(0, 255));
        end
      endcase
      set_percents(pa, pb);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int n = 0; n < SegmentItems; n++) begin
        // hold off once mid-stream until the pipe is empty
        if (seg == 5 && n == SegmentItems / 2) drain_pipe();
        send_pixel(rand_pixel(), rand_pixel(), rand_mask(), rand_mask(), rand_pixel(),
                   1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("run covered %0d pixels and %0d results over %0d percent settings",
             items_taken, pixels_checked, settings_used);
    $display("output stalls seen: %0d, mismatches: %0d", stalls_seen, fail_cnt);
    if (fail_cnt == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
